// File: hdl/nma_pkg.sv
// nma_pkg: shared widths and defaults for the nonzero moving average block
// no dependencies; imported by every module of the block but nma_ram
`timescale 1ns / 1ps

package nma_pkg;

    localparam int SAMPLE_W    = 11;
    localparam int COUNT_W     = 4;
    localparam int DEF_WINDOW  = 8;
    localparam int QUEUE_DEPTH = 2;

endpackage

// File: hdl/nonzero_moving_average.sv
// nonzero_moving_average: mean of the nonzero samples among the last WINDOW samples
// a result passes the front update state, the queue and the back divider states to the output register
// the back end divides one quotient bit per cycle and takes no new request until its result is taken
// front end takes a new sample while the back end divides, as long as the two-entry queue has room
// synchronous active-low reset clears the ring valid bits, sums, pointers and handshakes
`timescale 1ns / 1ps

module nonzero_moving_average
    import nma_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_average,
    output logic [COUNT_W-1:0]         o_used_count
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;

    logic                   w_push;
    logic                   w_pop;
    logic                   w_full;
    logic                   w_empty;
    logic [SUM_W+CNT_W-1:0] w_push_data;
    logic [SUM_W+CNT_W-1:0] w_pop_data;

    nma_front #(
        .WINDOW (WINDOW),
        .SLOT_W (SLOT_W),
        .CNT_W  (CNT_W),
        .SUM_W  (SUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_data   (w_push_data)
    );

    nma_queue #(
        .WIDTH (SUM_W + CNT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    nma_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_data       (w_pop_data),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_average    (o_average),
        .o_used_count (o_used_count)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("request pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("request popped from empty queue");

    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (WINDOW < 16) && o_used_count == '0) |-> o_average == '0)
        else $error("nonzero average with no samples");

    a_pop_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> !o_valid)
        else $error("result shown while divider loading");

endmodule

// File: hdl/nma_ram.sv
// nma_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module nma_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/nma_front.sv
// nma_front: accepts samples, updates the sample ring and the running sum and count
// depends on nma_pkg and nma_ram; pushes sum and count requests into the queue
`timescale 1ns / 1ps

module nma_front
    import nma_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW,
    parameter int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    parameter int CNT_W  = $clog2(WINDOW + 1),
    parameter int SUM_W  = SAMPLE_W + CNT_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                    i_full,
    output logic                    o_push,
    output logic [SUM_W+CNT_W-1:0]  o_data
);

    typedef enum logic {S_IDLE, S_UPD} t_state;

    t_state                r_state;
    logic [SAMPLE_W-1:0]   r_sample;
    logic [SLOT_W-1:0]     r_slot;
    logic [WINDOW-1:0]     r_valid;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]      r_cnt;

    logic [SAMPLE_W-1:0]   w_rdata;
    logic [SAMPLE_W-1:0]   w_old;
    logic signed [SUM_W-1:0] w_old_ext;
    logic signed [SUM_W-1:0] w_new_ext;
    logic signed [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0]      n_cnt;
    logic                  w_write;

    assign o_stall = (r_state != S_IDLE);
    assign w_write = (r_state == S_UPD) && !i_full;
    assign o_push  = w_write;

    // slot never written since reset reads as empty
    assign w_old     = r_valid[r_slot] ? w_rdata : '0;
    assign w_old_ext = {{(SUM_W-SAMPLE_W){w_old[SAMPLE_W-1]}}, w_old};
    assign w_new_ext = {{(SUM_W-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};

    always_comb begin
        n_sum = r_sum - w_old_ext + w_new_ext;
        n_cnt = r_cnt;
        if (w_old != '0) begin
            n_cnt = n_cnt - CNT_W'(1);
        end
        if (r_sample != '0) begin
            n_cnt = n_cnt + CNT_W'(1);
        end
    end

    assign o_data = {n_sum, n_cnt};

    nma_ram #(
        .WIDTH  (SAMPLE_W),
        .DEPTH  (WINDOW),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (r_slot),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_valid <= '0;
            r_sum   <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_sample <= i_sample;
                        r_state  <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (!i_full) begin
                        r_valid[r_slot] <= 1'b1;
                        r_sum           <= n_sum;
                        r_cnt           <= n_cnt;
                        r_slot          <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0
                                                                         : r_slot + SLOT_W'(1);
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/nma_queue.sv
// nma_queue: two-entry register queue between the front and back ends
// depends on nma_pkg for its depth
`timescale 1ns / 1ps

module nma_queue
    import nma_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [LVL_W-1:0] r_lvl;

    assign o_full  = (r_lvl == LVL_W'(QUEUE_DEPTH));
    assign o_empty = (r_lvl == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_lvl <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_lvl <= r_lvl + LVL_W'(1);
            end else if (i_pop && !i_push) begin
                r_lvl <= r_lvl - LVL_W'(1);
            end
        end
    end

endmodule

// File: hdl/nma_back.sv
// nma_back: restoring divider, one quotient bit a cycle, and the output register
// depends on nma_pkg; pops sum and count requests from the queue
`timescale 1ns / 1ps

module nma_back
    import nma_pkg::*;
#(
    parameter int CNT_W = 4,
    parameter int SUM_W = SAMPLE_W + CNT_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  logic [SUM_W+CNT_W-1:0]     i_data,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_average,
    output logic [COUNT_W-1:0]         o_used_count
);

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} t_state;

    t_state           r_state;
    logic [SUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic             r_neg;
    logic [STEP_W-1:0] r_step;

    logic signed [SUM_W-1:0] w_sum;
    logic [CNT_W-1:0]  w_cnt;
    logic [SUM_W-1:0]  w_mag;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;
    logic [CNT_W-1:0]  n_rem;
    logic [SUM_W-1:0]  n_quo;
    logic [SUM_W-1:0]  w_res;
    logic [CNT_W+COUNT_W-1:0] w_cnt_ext;

    assign w_sum = i_data[SUM_W+CNT_W-1:CNT_W];
    assign w_cnt = i_data[CNT_W-1:0];
    assign w_mag = w_sum[SUM_W-1] ? SUM_W'(-w_sum) : SUM_W'(w_sum);

    assign w_trial = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign n_rem   = w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
    assign n_quo   = {r_quo[SUM_W-2:0], w_ge};
    assign w_res   = r_neg ? (~n_quo + SUM_W'(1)) : n_quo;

    assign w_cnt_ext = {{COUNT_W{1'b0}}, w_cnt};

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_quo        <= w_mag;
                        r_rem        <= '0;
                        r_div        <= w_cnt;
                        r_neg        <= w_sum[SUM_W-1];
                        r_step       <= STEP_W'(SUM_W - 1);
                        o_used_count <= w_cnt_ext[COUNT_W-1:0];
                        r_state      <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo  <= n_quo;
                    r_rem  <= n_rem;
                    r_step <= r_step - STEP_W'(1);
                    if (r_step == '0) begin
                        // no nonzero samples gives zero
                        o_average <= (r_div == '0) ? '0 : w_res[SAMPLE_W-1:0];
                        o_valid   <= 1'b1;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
